>>> src/wtcg_pkg.sv
// Shared widths, register codes and reset values for the wall texel coordinate generator.
package wtcg_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int ROW_W   = 12;
    localparam int LH_W    = 16;
    localparam int POS_W   = 24;
    localparam int RAY_W   = 18;
    localparam int DIST_W  = 24;
    localparam int TW_W    = 11;
    localparam int TH_W    = 11;
    localparam int PITCH_W = 13;
    localparam int SH_W    = 13;
    localparam int CFG_W   = 13;
    localparam int SEL_W   = 2;
    localparam int TEX_W   = 10;
    localparam int OFS_W   = 22;

    // row - sh/2 + lh/2 + 1 spans -4094..36863
    localparam int NUM_W  = 18;
    localparam int NUMP_W = 16;
    // quotient bits kept; anything at or past 2^QUO_W saturates anyway
    localparam int QUO_W  = TH_W;
    localparam int DVD_W  = NUMP_W + TH_W;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH  = 2'd0,
        CFG_TEX_HEIGHT = 2'd1,
        CFG_ROW_PITCH  = 2'd2,
        CFG_SCREEN_H   = 2'd3
    } t_cfg_idx;

    localparam logic [TW_W-1:0]    TEX_WIDTH_RST  = TW_W'(64);
    localparam logic [TH_W-1:0]    TEX_HEIGHT_RST = TH_W'(64);
    localparam logic [PITCH_W-1:0] ROW_PITCH_RST  = PITCH_W'(256);
    localparam logic [SH_W-1:0]    SCREEN_H_RST   = SH_W'(720);

    // texture choice from hit side and ray sign
    localparam logic [SEL_W-1:0] SEL_VERT_NEG = 2'd0;
    localparam logic [SEL_W-1:0] SEL_VERT_POS = 2'd1;
    localparam logic [SEL_W-1:0] SEL_HORZ_POS = 2'd2;
    localparam logic [SEL_W-1:0] SEL_HORZ_NEG = 2'd3;

endpackage

>>> src/wtcg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband that rides along.
module wtcg_div #(
    parameter int QBITS  = wtcg_pkg::QUO_W,
    parameter int DBITS  = wtcg_pkg::LH_W,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [DBITS-1:0]  i_rem,
    input  logic [QBITS-1:0]  i_low,
    input  logic [DBITS-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [QBITS-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [QBITS];
    logic [DBITS-1:0]  r_rem  [QBITS];
    logic [QBITS-1:0]  r_low  [QBITS];
    logic [QBITS-1:0]  r_q    [QBITS];
    logic [DBITS-1:0]  r_den  [QBITS];
    logic [SIDE_W-1:0] r_side [QBITS];

    logic [QBITS:0] rdy_chain;

    always_comb begin
        rdy_chain[QBITS] = i_rdy;
        for (int k = QBITS - 1; k >= 0; k--) begin
            rdy_chain[k] = !r_vld[k] || rdy_chain[k+1];
        end
    end

    assign o_rdy  = rdy_chain[0];
    assign o_vld  = r_vld[QBITS-1];
    assign o_quo  = r_q[QBITS-1];
    assign o_side = r_side[QBITS-1];

    for (genvar k = 0; k < QBITS; k++) begin : g_step
        logic              src_vld;
        logic [DBITS-1:0]  src_rem;
        logic [QBITS-1:0]  src_low;
        logic [QBITS-1:0]  src_q;
        logic [DBITS-1:0]  src_den;
        logic [SIDE_W-1:0] src_side;
        logic [DBITS:0]    trial;
        logic [DBITS:0]    diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign src_vld  = i_vld;
            assign src_rem  = i_rem;
            assign src_low  = i_low;
            assign src_q    = '0;
            assign src_den  = i_den;
            assign src_side = i_side;
        end else begin : g_next
            assign src_vld  = r_vld[k-1];
            assign src_rem  = r_rem[k-1];
            assign src_low  = r_low[k-1];
            assign src_q    = r_q[k-1];
            assign src_den  = r_den[k-1];
            assign src_side = r_side[k-1];
        end

        assign trial = {src_rem, src_low[QBITS-1]};
        assign diff  = trial - {1'b0, src_den};
        assign ge    = (trial >= {1'b0, src_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy_chain[k]) begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy_chain[k]) begin
                r_rem[k]  <= ge ? diff[DBITS-1:0] : trial[DBITS-1:0];
                r_low[k]  <= src_low << 1;
                r_q[k]    <= {src_q[QBITS-2:0], ge};
                r_den[k]  <= src_den;
                r_side[k] <= src_side;
            end
        end
    end

endmodule

>>> src/wall_texel_coordinate_generator.sv
// Wall texel coordinate generator: one screen pixel of a wall column in, one texel address out.
//
// Takes one pixel item per clock while no back-pressure holds the pipeline, and returns its
// texture index, texel column, texel row and byte offset through 3 front stages, 11 divider
// stages and 3 back stages. The texel row divider resolves one quotient bit per stage, and the
// hit point and texel column multiplies sit in the front and back stages around it. Each
// stage holds its item while the next one is full, so empty slots close up under back-pressure.
// Registers are written through the plain write port and must only change while the block
// holds no item. A pixel whose deciding ray component is zero comes out with draw low and all
// fields zero.
module wall_texel_coordinate_generator #(
    parameter int FRAC_BITS = wtcg_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_wen,
    input  logic [wtcg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wtcg_pkg::CFG_W-1:0]    i_cfg_wdata,
    // pixel items in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // row, line_height, pos_vert, pos_horz, ray_vert, ray_horz, perp_dist
    input  logic [135:0]                  s_axis_tdata,
    // hit_side
    input  logic [0:0]                    s_axis_tuser,
    // texel items out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // texel_x, texel_y, texel_offset, zero pad
    output logic [47:0]                   m_axis_tdata,
    // draw, texture_select
    output logic [2:0]                    m_axis_tuser
);

    localparam int FRAC_W = 2 * FRAC_BITS;

    localparam int ROW_LSB  = 0;
    localparam int LH_LSB   = ROW_LSB + wtcg_pkg::ROW_W;
    localparam int PV_LSB   = LH_LSB + wtcg_pkg::LH_W;
    localparam int PH_LSB   = PV_LSB + wtcg_pkg::POS_W;
    localparam int RV_LSB   = PH_LSB + wtcg_pkg::POS_W;
    localparam int RH_LSB   = RV_LSB + wtcg_pkg::RAY_W;
    localparam int PD_LSB   = RH_LSB + wtcg_pkg::RAY_W;
    localparam int IN_END   = PD_LSB + wtcg_pkg::DIST_W;
    localparam int PROD_W   = wtcg_pkg::DIST_W + 1 + wtcg_pkg::RAY_W;
    localparam int TXP_W    = FRAC_W + wtcg_pkg::TW_W;
    localparam int SIDE_W   = 1 + wtcg_pkg::SEL_W + 1 + FRAC_W + 1 + 1;
    localparam int OUT_BITS = 2 * wtcg_pkg::TEX_W + wtcg_pkg::OFS_W;

    // ---------------- configuration registers ----------------
    logic [wtcg_pkg::TW_W-1:0]    r_tex_width;
    logic [wtcg_pkg::TH_W-1:0]    r_tex_height;
    logic [wtcg_pkg::PITCH_W-1:0] r_row_pitch;
    logic [wtcg_pkg::SH_W-1:0]    r_screen_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= wtcg_pkg::TEX_WIDTH_RST;
            r_tex_height <= wtcg_pkg::TEX_HEIGHT_RST;
            r_row_pitch  <= wtcg_pkg::ROW_PITCH_RST;
            r_screen_h   <= wtcg_pkg::SCREEN_H_RST;
        end else if (i_cfg_wen) begin
            unique case (wtcg_pkg::t_cfg_idx'(i_cfg_idx))
                wtcg_pkg::CFG_TEX_WIDTH:  r_tex_width  <= i_cfg_wdata[wtcg_pkg::TW_W-1:0];
                wtcg_pkg::CFG_TEX_HEIGHT: r_tex_height <= i_cfg_wdata[wtcg_pkg::TH_W-1:0];
                wtcg_pkg::CFG_ROW_PITCH:  r_row_pitch  <= i_cfg_wdata;
                wtcg_pkg::CFG_SCREEN_H:   r_screen_h   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- input unpack and decode ----------------
    logic [wtcg_pkg::ROW_W-1:0]         in_row;
    logic [wtcg_pkg::LH_W-1:0]          in_lh;
    logic                               in_side;
    logic [wtcg_pkg::POS_W-1:0]         in_pv;
    logic [wtcg_pkg::POS_W-1:0]         in_ph;
    logic signed [wtcg_pkg::RAY_W-1:0]  in_rv;
    logic signed [wtcg_pkg::RAY_W-1:0]  in_rh;
    logic [wtcg_pkg::DIST_W-1:0]        in_pd;
    logic                               dec_draw;
    logic [wtcg_pkg::SEL_W-1:0]         dec_sel;
    logic                               dec_mirror;
    logic [wtcg_pkg::POS_W-1:0]         dec_pos;
    logic signed [wtcg_pkg::RAY_W-1:0]  dec_ray;
    logic [wtcg_pkg::NUM_W-1:0]         dec_num;

    assign in_row  = s_axis_tdata[LH_LSB-1:ROW_LSB];
    assign in_lh   = s_axis_tdata[PV_LSB-1:LH_LSB];
    assign in_pv   = s_axis_tdata[PH_LSB-1:PV_LSB];
    assign in_ph   = s_axis_tdata[RV_LSB-1:PH_LSB];
    assign in_rv   = $signed(s_axis_tdata[RH_LSB-1:RV_LSB]);
    assign in_rh   = $signed(s_axis_tdata[PD_LSB-1:RH_LSB]);
    assign in_pd   = s_axis_tdata[IN_END-1:PD_LSB];
    assign in_side = s_axis_tuser[0];

    always_comb begin
        if (!in_side) begin
            dec_draw   = (in_rh != '0);
            dec_sel    = in_rh[wtcg_pkg::RAY_W-1] ? wtcg_pkg::SEL_HORZ_NEG
                                                  : wtcg_pkg::SEL_HORZ_POS;
            dec_mirror = in_rh[wtcg_pkg::RAY_W-1];
            dec_pos    = in_pv;
            dec_ray    = in_rv;
        end else begin
            dec_draw   = (in_rv != '0);
            dec_sel    = in_rv[wtcg_pkg::RAY_W-1] ? wtcg_pkg::SEL_VERT_NEG
                                                  : wtcg_pkg::SEL_VERT_POS;
            dec_mirror = !in_rv[wtcg_pkg::RAY_W-1] && (in_rv != '0);
            dec_pos    = in_ph;
            dec_ray    = in_rh;
        end
        // both halvings truncate
        dec_num = wtcg_pkg::NUM_W'(in_row)
                - wtcg_pkg::NUM_W'(r_screen_h[wtcg_pkg::SH_W-1:1])
                + wtcg_pkg::NUM_W'(in_lh[wtcg_pkg::LH_W-1:1])
                + wtcg_pkg::NUM_W'(1);
    end

    // ---------------- pipeline handshake ----------------
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    logic adv_a, adv_b, adv_c, adv_d, adv_e, adv_f;
    logic div_in_rdy, div_out_vld;

    assign adv_f = !r_f_vld || m_axis_tready;
    assign adv_e = !r_e_vld || adv_f;
    assign adv_d = !r_d_vld || adv_e;
    assign adv_c = !r_c_vld || div_in_rdy;
    assign adv_b = !r_b_vld || adv_c;
    assign adv_a = !r_a_vld || adv_b;
    assign s_axis_tready = adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            if (adv_a) r_a_vld <= s_axis_tvalid;
            if (adv_b) r_b_vld <= r_a_vld;
            if (adv_c) r_c_vld <= r_b_vld;
            if (adv_d) r_d_vld <= div_out_vld;
            if (adv_e) r_e_vld <= r_d_vld;
            if (adv_f) r_f_vld <= r_e_vld;
        end
    end

    // ---------------- stage A: decode ----------------
    logic                               r_a_draw;
    logic [wtcg_pkg::SEL_W-1:0]         r_a_sel;
    logic                               r_a_mirror;
    logic [FRAC_W-1:0]                  r_a_pos_sh;
    logic signed [wtcg_pkg::RAY_W-1:0]  r_a_ray;
    logic [wtcg_pkg::DIST_W-1:0]        r_a_pd;
    logic                               r_a_num_pos;
    logic [wtcg_pkg::NUMP_W-1:0]        r_a_num;
    logic [wtcg_pkg::LH_W-1:0]          r_a_lh;

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_draw    <= dec_draw;
            r_a_sel     <= dec_sel;
            r_a_mirror  <= dec_mirror;
            r_a_pos_sh  <= FRAC_W'({dec_pos, {FRAC_BITS{1'b0}}});
            r_a_ray     <= dec_ray;
            r_a_pd      <= in_pd;
            r_a_num_pos <= !dec_num[wtcg_pkg::NUM_W-1] && (dec_num != '0);
            r_a_num     <= dec_num[wtcg_pkg::NUMP_W-1:0];
            r_a_lh      <= in_lh;
        end
    end

    // ---------------- stage B: multiplies ----------------
    logic signed [PROD_W-1:0]      hit_prod;
    logic [wtcg_pkg::DVD_W-1:0]    dvd_prod;

    assign hit_prod = $signed({1'b0, r_a_pd}) * r_a_ray;
    assign dvd_prod = r_a_num * r_tex_height;

    logic                          r_b_draw;
    logic [wtcg_pkg::SEL_W-1:0]    r_b_sel;
    logic                          r_b_mirror;
    logic [FRAC_W-1:0]             r_b_pos_sh;
    logic [FRAC_W-1:0]             r_b_prod;
    logic                          r_b_num_pos;
    logic [wtcg_pkg::DVD_W-1:0]    r_b_dvd;
    logic [wtcg_pkg::LH_W-1:0]     r_b_lh;

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_b_draw    <= r_a_draw;
            r_b_sel     <= r_a_sel;
            r_b_mirror  <= r_a_mirror;
            r_b_pos_sh  <= r_a_pos_sh;
            r_b_prod    <= FRAC_W'(hit_prod);
            r_b_num_pos <= r_a_num_pos;
            r_b_dvd     <= dvd_prod;
            r_b_lh      <= r_a_lh;
        end
    end

    // ---------------- stage C: hit fraction, quotient range check ----------------
    logic                          r_c_draw;
    logic [wtcg_pkg::SEL_W-1:0]    r_c_sel;
    logic                          r_c_mirror;
    logic [FRAC_W-1:0]             r_c_frac;
    logic                          r_c_num_pos;
    logic                          r_c_ovf;
    logic [wtcg_pkg::DVD_W-1:0]    r_c_dvd;
    logic [wtcg_pkg::LH_W-1:0]     r_c_lh;

    always_ff @(posedge i_clk) begin
        if (adv_c) begin
            r_c_draw    <= r_b_draw;
            r_c_sel     <= r_b_sel;
            r_c_mirror  <= r_b_mirror;
            r_c_frac    <= r_b_pos_sh + r_b_prod;
            r_c_num_pos <= r_b_num_pos;
            // zero line height or a quotient past QUO_W bits both clamp to the last texel row
            r_c_ovf     <= (r_b_lh == '0)
                        || (r_b_dvd >= {r_b_lh, {wtcg_pkg::QUO_W{1'b0}}});
            r_c_dvd     <= r_b_dvd;
            r_c_lh      <= r_b_lh;
        end
    end

    // ---------------- divider ----------------
    logic [SIDE_W-1:0]           div_side_in;
    logic [SIDE_W-1:0]           div_side_out;
    logic [wtcg_pkg::QUO_W-1:0]  div_quo;

    assign div_side_in = {r_c_draw, r_c_sel, r_c_mirror, r_c_frac, r_c_num_pos, r_c_ovf};

    wtcg_div #(
        .QBITS  (wtcg_pkg::QUO_W),
        .DBITS  (wtcg_pkg::LH_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .o_rdy   (div_in_rdy),
        .i_rem   (r_c_dvd[wtcg_pkg::DVD_W-1:wtcg_pkg::QUO_W]),
        .i_low   (r_c_dvd[wtcg_pkg::QUO_W-1:0]),
        .i_den   (r_c_lh),
        .i_side  (div_side_in),
        .o_vld   (div_out_vld),
        .i_rdy   (adv_d),
        .o_quo   (div_quo),
        .o_side  (div_side_out)
    );

    logic                          dv_draw;
    logic [wtcg_pkg::SEL_W-1:0]    dv_sel;
    logic                          dv_mirror;
    logic [FRAC_W-1:0]             dv_frac;
    logic                          dv_num_pos;
    logic                          dv_ovf;

    assign {dv_draw, dv_sel, dv_mirror, dv_frac, dv_num_pos, dv_ovf} = div_side_out;

    // ---------------- stage D: texel column scale, texel row clamp ----------------
    logic [TXP_W-1:0]              tx_prod;
    logic [wtcg_pkg::TH_W-1:0]     th_m1;
    logic [wtcg_pkg::TH_W-1:0]     ty_clamp;
    logic [wtcg_pkg::TEX_W-1:0]    ty_sat;

    assign tx_prod = dv_frac * r_tex_width;
    assign th_m1   = r_tex_height - wtcg_pkg::TH_W'(1);

    always_comb begin
        if (!dv_num_pos || (r_tex_height == '0)) begin
            ty_clamp = '0;
        end else if (dv_ovf || (div_quo > th_m1)) begin
            ty_clamp = th_m1;
        end else begin
            ty_clamp = div_quo;
        end
        ty_sat = ty_clamp[wtcg_pkg::TH_W-1] ? '1 : ty_clamp[wtcg_pkg::TEX_W-1:0];
    end

    logic                          r_d_draw;
    logic [wtcg_pkg::SEL_W-1:0]    r_d_sel;
    logic                          r_d_mirror;
    logic [wtcg_pkg::TW_W-1:0]     r_d_tx_raw;
    logic [wtcg_pkg::TEX_W-1:0]    r_d_ty;

    always_ff @(posedge i_clk) begin
        if (adv_d) begin
            r_d_draw   <= dv_draw;
            r_d_sel    <= dv_sel;
            r_d_mirror <= dv_mirror;
            r_d_tx_raw <= tx_prod[TXP_W-1:FRAC_W];
            r_d_ty     <= ty_sat;
        end
    end

    // ---------------- stage E: mirror and clamp texel column ----------------
    logic [wtcg_pkg::TW_W-1:0]     tx_mir;
    logic [wtcg_pkg::TEX_W-1:0]    tx_sat;

    always_comb begin
        if (!r_d_mirror) begin
            tx_mir = r_d_tx_raw;
        end else if (r_d_tx_raw < r_tex_width) begin
            tx_mir = r_tex_width - r_d_tx_raw - wtcg_pkg::TW_W'(1);
        end else begin
            tx_mir = '0;
        end
        tx_sat = tx_mir[wtcg_pkg::TW_W-1] ? '1 : tx_mir[wtcg_pkg::TEX_W-1:0];
    end

    logic                          r_e_draw;
    logic [wtcg_pkg::SEL_W-1:0]    r_e_sel;
    logic [wtcg_pkg::TEX_W-1:0]    r_e_tx;
    logic [wtcg_pkg::TEX_W-1:0]    r_e_ty;

    always_ff @(posedge i_clk) begin
        if (adv_e) begin
            r_e_draw <= r_d_draw;
            r_e_sel  <= r_d_sel;
            r_e_tx   <= tx_sat;
            r_e_ty   <= r_d_ty;
        end
    end

    // ---------------- stage F: byte offset, output register ----------------
    logic [wtcg_pkg::TEX_W+wtcg_pkg::PITCH_W-1:0] row_bytes;
    logic [wtcg_pkg::OFS_W-1:0]                   ofs;

    assign row_bytes = r_e_ty * r_row_pitch;
    assign ofs = row_bytes[wtcg_pkg::OFS_W-1:0]
               + wtcg_pkg::OFS_W'({r_e_tx, 2'b00});

    logic                          r_f_draw;
    logic [wtcg_pkg::SEL_W-1:0]    r_f_sel;
    logic [wtcg_pkg::TEX_W-1:0]    r_f_tx;
    logic [wtcg_pkg::TEX_W-1:0]    r_f_ty;
    logic [wtcg_pkg::OFS_W-1:0]    r_f_ofs;

    // items without a texture leave with every field zero
    always_ff @(posedge i_clk) begin
        if (adv_f) begin
            r_f_draw <= r_e_draw;
            r_f_sel  <= r_e_draw ? r_e_sel : '0;
            r_f_tx   <= r_e_draw ? r_e_tx  : '0;
            r_f_ty   <= r_e_draw ? r_e_ty  : '0;
            r_f_ofs  <= r_e_draw ? ofs     : '0;
        end
    end

    assign m_axis_tvalid = r_f_vld;
    assign m_axis_tdata  = {{(48 - OUT_BITS){1'b0}}, r_f_ofs, r_f_ty, r_f_tx};
    assign m_axis_tuser  = {r_f_sel, r_f_draw};

endmodule
